@@ src/ntc_pkg.sv @@
// Package for the numeric type converter: word structs, source type codes
// and the internal operation kinds. No dependencies.
`default_nettype none
package ntc_pkg;

    typedef struct packed {
        logic [63:0] raw_bytes;
        logic [3:0]  type_code;
        logic        func;
    } t_in_word;

    typedef struct packed {
        logic [31:0] value_bits;
        logic        invalid;
    } t_out_word;

    typedef enum logic [3:0] {
        TC_I8  = 4'd0,
        TC_U8  = 4'd1,
        TC_I16 = 4'd2,
        TC_U16 = 4'd3,
        TC_I32 = 4'd4,
        TC_U32 = 4'd5,
        TC_F32 = 4'd6,
        TC_F64 = 4'd7
    } t_type_code;

    typedef enum logic [1:0] {
        K_CONST = 2'd0,
        K_FLT   = 2'd1,
        K_INT   = 2'd2
    } t_kind;

    localparam logic [31:0] FP32_INF  = 32'h7F80_0000;
    localparam logic [31:0] FP32_QNAN = 32'h7FC0_0000;
    localparam logic [31:0] I32_MAX   = 32'h7FFF_FFFF;
    localparam logic [31:0] I32_MIN   = 32'h8000_0000;

endpackage
`default_nettype wire

@@ src/numeric_type_converter.sv @@
// Numeric type converter: one input word in, one fp32 or int32 word out.
// One word is accepted every cycle; the pipeline holds while the output is stalled.
// The five stages are decode, leading-zero count, normalize, align and round or clamp.
// Synchronous active-low reset clears the stage valid bits; data is not reset.
// Depends on ntc_pkg.
`default_nettype none
module numeric_type_converter (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_in_valid,
    output logic                o_in_stall,
    input  ntc_pkg::t_in_word   i_in,
    output logic                o_out_valid,
    input  wire                 i_out_stall,
    output ntc_pkg::t_out_word  o_out
);

    logic en;

    // Stage 1: decode.
    logic                r_v1;
    ntc_pkg::t_kind      r_kind1, n_kind1;
    logic [31:0]         r_cval1, n_cval1;
    logic                r_cinv1, n_cinv1;
    logic                r_sign1, n_sign1;
    logic [63:0]         r_sig1, n_sig1;
    logic signed [11:0]  r_ex1, n_ex1;

    // Stage 2: leading zeros.
    logic                r_v2;
    ntc_pkg::t_kind      r_kind2;
    logic [31:0]         r_cval2;
    logic                r_cinv2;
    logic                r_sign2;
    logic [63:0]         r_sig2;
    logic signed [11:0]  r_ex2;
    logic [5:0]          r_lz2, n_lz2;

    // Stage 3: normalize.
    logic                r_v3;
    ntc_pkg::t_kind      r_kind3;
    logic [31:0]         r_cval3;
    logic                r_cinv3;
    logic                r_sign3;
    logic [63:0]         r_n3;
    logic signed [11:0]  r_be3;

    // Stage 4: align.
    logic                r_v4;
    ntc_pkg::t_kind      r_kind4;
    logic [31:0]         r_cval4;
    logic                r_cinv4;
    logic                r_sign4;
    logic [63:0]         r_m4, n_m4;
    logic                r_st4, n_st4;
    logic signed [11:0]  r_q4, n_q4;
    logic                r_ovf4, n_ovf4;
    logic [31:0]         r_mag4, n_mag4;
    logic                r_big4, n_big4;

    // Stage 5: output register.
    logic                r_v5;
    ntc_pkg::t_out_word  r_out5, n_out5;

    assign en          = !(r_v5 && i_out_stall);
    assign o_in_stall  = r_v5 && i_out_stall;
    assign o_out_valid = r_v5;
    assign o_out       = r_out5;

    always_comb begin
        logic [31:0] lo, ibits, mag;
        logic        neg;
        logic [7:0]  e8;
        logic [10:0] e11;
        logic [3:0]  code;
        code    = i_in.type_code;
        lo      = i_in.raw_bytes[31:0];
        n_kind1 = ntc_pkg::K_CONST;
        n_cval1 = 32'd0;
        n_cinv1 = 1'b0;
        n_sign1 = 1'b0;
        n_sig1  = 64'd0;
        n_ex1   = 12'sd0;
        ibits   = lo;
        mag     = 32'd0;
        neg     = 1'b0;
        e8      = lo[30:23];
        e11     = i_in.raw_bytes[62:52];
        case (code)
            ntc_pkg::TC_I8, ntc_pkg::TC_U8, ntc_pkg::TC_I16, ntc_pkg::TC_U16,
            ntc_pkg::TC_I32, ntc_pkg::TC_U32: begin
                case (code)
                    ntc_pkg::TC_I8:  ibits = {{24{lo[7]}}, lo[7:0]};
                    ntc_pkg::TC_U8:  ibits = {24'd0, lo[7:0]};
                    ntc_pkg::TC_I16: ibits = {{16{lo[15]}}, lo[15:0]};
                    ntc_pkg::TC_U16: ibits = {16'd0, lo[15:0]};
                    default:         ibits = lo;
                endcase
                if (i_in.func) begin
                    n_cval1 = ibits;
                end else begin
                    neg = (code != ntc_pkg::TC_U32) && ibits[31];
                    mag = neg ? (32'd0 - ibits) : ibits;
                    if (mag != 32'd0) begin
                        n_kind1 = ntc_pkg::K_FLT;
                        n_sign1 = neg;
                        n_sig1  = {32'd0, mag};
                    end
                end
            end
            ntc_pkg::TC_F32: begin
                if (!i_in.func) begin
                    n_cval1 = lo;
                end else if (e8 == 8'hFF) begin
                    n_cinv1 = 1'b1;
                    if (lo[22:0] != 23'd0) n_cval1 = 32'd0;
                    else n_cval1 = lo[31] ? ntc_pkg::I32_MIN : ntc_pkg::I32_MAX;
                end else if (e8 == 8'd0) begin
                    n_sign1 = lo[31];
                    n_sig1  = {41'd0, lo[22:0]};
                    n_ex1   = -12'sd149;
                    if (lo[22:0] != 23'd0) n_kind1 = ntc_pkg::K_INT;
                end else begin
                    n_kind1 = ntc_pkg::K_INT;
                    n_sign1 = lo[31];
                    n_sig1  = {40'd0, 1'b1, lo[22:0]};
                    n_ex1   = $signed({4'd0, e8}) - 12'sd150;
                end
            end
            ntc_pkg::TC_F64: begin
                n_sign1 = i_in.raw_bytes[63];
                if (e11 == 11'h7FF) begin
                    if (i_in.func) begin
                        n_cinv1 = 1'b1;
                        if (i_in.raw_bytes[51:0] != 52'd0) n_cval1 = 32'd0;
                        else n_cval1 = i_in.raw_bytes[63] ? ntc_pkg::I32_MIN
                                                          : ntc_pkg::I32_MAX;
                    end else if (i_in.raw_bytes[51:0] == 52'd0) begin
                        n_cval1 = {i_in.raw_bytes[63], 31'd0} | ntc_pkg::FP32_INF;
                    end else begin
                        n_cval1 = {i_in.raw_bytes[63], 31'd0} | ntc_pkg::FP32_QNAN
                                  | {10'd0, i_in.raw_bytes[51:30]};
                    end
                end else begin
                    if (e11 == 11'd0) begin
                        n_sig1 = {12'd0, i_in.raw_bytes[51:0]};
                        n_ex1  = -12'sd1074;
                    end else begin
                        n_sig1 = {11'd0, 1'b1, i_in.raw_bytes[51:0]};
                        n_ex1  = $signed({1'b0, e11}) - 12'sd1075;
                    end
                    if (n_sig1 == 64'd0) begin
                        n_cval1 = i_in.func ? 32'd0 : {i_in.raw_bytes[63], 31'd0};
                    end else begin
                        n_kind1 = i_in.func ? ntc_pkg::K_INT : ntc_pkg::K_FLT;
                    end
                end
            end
            default: begin
                n_cval1 = 32'd0;
            end
        endcase
    end

    always_comb begin
        n_lz2 = 6'd0;
        for (int i = 0; i < 64; i++) begin
            if (r_sig1[i]) n_lz2 = 6'(63 - i);
        end
    end

    always_comb begin
        logic signed [11:0] shraw;
        logic [4:0]         sh;
        shraw  = -12'sd126 - r_be3;
        sh     = 5'd0;
        n_q4   = r_be3 - 12'sd23;
        if (r_be3 < -12'sd126) begin
            n_q4 = -12'sd149;
            sh   = (shraw > 12'sd26) ? 5'd26 : shraw[4:0];
        end
        n_m4   = r_n3 >> sh;
        n_st4  = |(r_n3 & ~({64{1'b1}} << sh));
        n_ovf4 = r_be3 > 12'sd127;
        n_big4 = r_be3 >= 12'sd32;
        n_mag4 = 32'd0;
        if (!n_big4 && r_be3 >= 12'sd0) begin
            n_mag4 = 32'(r_n3 >> (6'd63 - r_be3[5:0]));
        end
    end

    always_comb begin
        logic [23:0]        kept;
        logic               inc;
        logic [24:0]        m25;
        logic [23:0]        mm;
        logic signed [11:0] q2, exf;
        kept = r_m4[63:40];
        inc  = r_m4[39] && ((|r_m4[38:0]) || r_st4 || kept[0]);
        m25  = {1'b0, kept} + 25'(inc);
        q2   = m25[24] ? (r_q4 + 12'sd1) : r_q4;
        mm   = m25[24] ? m25[24:1] : m25[23:0];
        exf  = q2 + 12'sd150;
        n_out5.value_bits = r_cval4;
        n_out5.invalid    = r_cinv4;
        case (r_kind4)
            ntc_pkg::K_FLT: begin
                n_out5.invalid = 1'b0;
                if (r_ovf4 || (mm[23] && exf >= 12'sd255)) begin
                    n_out5.value_bits = {r_sign4, 31'd0} | ntc_pkg::FP32_INF;
                end else if (!mm[23]) begin
                    n_out5.value_bits = {r_sign4, 8'd0, mm[22:0]};
                end else begin
                    n_out5.value_bits = {r_sign4, exf[7:0], mm[22:0]};
                end
            end
            ntc_pkg::K_INT: begin
                n_out5.invalid = 1'b0;
                if (r_sign4) begin
                    if (r_big4 || r_mag4 > ntc_pkg::I32_MIN) begin
                        n_out5.value_bits = ntc_pkg::I32_MIN;
                        n_out5.invalid    = 1'b1;
                    end else begin
                        n_out5.value_bits = 32'd0 - r_mag4;
                    end
                end else if (r_big4 || r_mag4 > ntc_pkg::I32_MAX) begin
                    n_out5.value_bits = ntc_pkg::I32_MAX;
                    n_out5.invalid    = 1'b1;
                end else begin
                    n_out5.value_bits = r_mag4;
                end
            end
            default: begin
                n_out5.value_bits = r_cval4;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (en) begin
            r_v1 <= i_in_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_kind1 <= n_kind1;
            r_cval1 <= n_cval1;
            r_cinv1 <= n_cinv1;
            r_sign1 <= n_sign1;
            r_sig1  <= n_sig1;
            r_ex1   <= n_ex1;

            r_kind2 <= r_kind1;
            r_cval2 <= r_cval1;
            r_cinv2 <= r_cinv1;
            r_sign2 <= r_sign1;
            r_sig2  <= r_sig1;
            r_ex2   <= r_ex1;
            r_lz2   <= n_lz2;

            r_kind3 <= r_kind2;
            r_cval3 <= r_cval2;
            r_cinv3 <= r_cinv2;
            r_sign3 <= r_sign2;
            r_n3    <= r_sig2 << r_lz2;
            r_be3   <= 12'sd63 - $signed({6'd0, r_lz2}) + r_ex2;

            r_kind4 <= r_kind3;
            r_cval4 <= r_cval3;
            r_cinv4 <= r_cinv3;
            r_sign4 <= r_sign3;
            r_m4    <= n_m4;
            r_st4   <= n_st4;
            r_q4    <= n_q4;
            r_ovf4  <= n_ovf4;
            r_mag4  <= n_mag4;
            r_big4  <= n_big4;

            r_out5  <= n_out5;
        end
    end

endmodule
`default_nettype wire

@@ test/tb.sv @@
// Self-checking testbench for numeric_type_converter: directed table of words followed by
// random words, checked against fixed words in the table or an fp32/int32 conversion predictor.
// Depends on ntc_pkg and numeric_type_converter.
`default_nettype none
module tb;

    logic                i_clk;
    logic                i_rst_n;
    logic                in_valid;
    logic                in_stall;
    ntc_pkg::t_in_word   in_word;
    logic                out_valid;
    logic                out_stall;
    ntc_pkg::t_out_word  out_word;

    ntc_pkg::t_out_word  expected_words[$];
    int                  fail_count;
    int                  send_idle_pct;
    int                  recv_stall_pct;
    logic                stim_done;

    numeric_type_converter i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in        (in_word),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out       (out_word)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] pack_single(logic sgn, logic [63:0] sig, int ex);
        int          p;
        int          big_e;
        int          q;
        int          d;
        logic [63:0] m;
        logic [63:0] kept;
        logic        rbit;
        logic        sticky;
        logic [31:0] s;
        s = {sgn, 31'd0};
        p = 63;
        while (sig[p] == 1'b0) p--;
        big_e = p + ex;
        if (big_e > 127) return s | ntc_pkg::FP32_INF;
        q = big_e - 23;
        if (q < -149) q = -149;
        d = q - ex;
        if (d <= 0) begin
            m = sig << (-d);
        end else begin
            if (d >= 64) begin
                kept = 64'd0;
                rbit = (d == 64) ? sig[63] : 1'b0;
                sticky = (d == 64) ? |sig[62:0] : |sig;
            end else begin
                kept = sig >> d;
                rbit = sig[d-1];
                sticky = |(sig & ((64'd1 << (d - 1)) - 64'd1));
            end
            m = kept;
            if (rbit && (sticky || kept[0])) m++;
        end
        if (m >= (64'd1 << 24)) begin
            m = m >> 1;
            q++;
        end
        if (m < (64'd1 << 23)) return s | m[31:0];
        if (q + 150 >= 255) return s | ntc_pkg::FP32_INF;
        return s | (32'(q + 150) << 23) | {9'd0, m[22:0]};
    endfunction

    function automatic logic [31:0] trunc_to_int(logic neg, logic [63:0] sig, int ex,
                                                 logic is_nan, logic is_inf,
                                                 output logic inv);
        logic [63:0] mag;
        logic        big;
        inv = 1'b0;
        big = 1'b0;
        mag = 64'd0;
        if (is_nan) begin
            inv = 1'b1;
            return 32'd0;
        end
        if (is_inf) begin
            big = 1'b1;
        end else if (ex >= 0) begin
            if (ex >= 32 || (sig >> (32 - ex)) != 64'd0) big = 1'b1;
            else mag = sig << ex;
        end else begin
            mag = (ex <= -64) ? 64'd0 : (sig >> (-ex));
        end
        if (neg) begin
            if (big || mag > 64'h8000_0000) begin
                inv = 1'b1;
                return ntc_pkg::I32_MIN;
            end
            return 32'd0 - mag[31:0];
        end
        if (big || mag > 64'h7FFF_FFFF) begin
            inv = 1'b1;
            return ntc_pkg::I32_MAX;
        end
        return mag[31:0];
    endfunction

    function automatic ntc_pkg::t_out_word convert_word(ntc_pkg::t_in_word w);
        ntc_pkg::t_out_word r;
        logic [31:0] lo;
        logic [31:0] ibits;
        logic [31:0] mag32;
        logic        neg;
        logic [10:0] e11;
        logic [51:0] f52;
        logic        inv;
        r = '0;
        inv = 1'b0;
        lo = w.raw_bytes[31:0];
        case (w.type_code)
            ntc_pkg::TC_I8, ntc_pkg::TC_U8, ntc_pkg::TC_I16, ntc_pkg::TC_U16,
            ntc_pkg::TC_I32, ntc_pkg::TC_U32: begin
                case (w.type_code)
                    ntc_pkg::TC_I8:  ibits = {{24{lo[7]}}, lo[7:0]};
                    ntc_pkg::TC_U8:  ibits = {24'd0, lo[7:0]};
                    ntc_pkg::TC_I16: ibits = {{16{lo[15]}}, lo[15:0]};
                    ntc_pkg::TC_U16: ibits = {16'd0, lo[15:0]};
                    default: ibits = lo;
                endcase
                if (w.func) begin
                    r.value_bits = ibits;
                end else begin
                    neg = (w.type_code != ntc_pkg::TC_U32) && ibits[31];
                    mag32 = neg ? 32'd0 - ibits : ibits;
                    r.value_bits = (mag32 == 0) ? 32'd0
                                 : pack_single(neg, {32'd0, mag32}, 0);
                end
            end
            ntc_pkg::TC_F32: begin
                if (!w.func) begin
                    r.value_bits = lo;
                end else if (lo[30:23] == 8'hFF) begin
                    r.value_bits = trunc_to_int(lo[31], 64'd0, 0, |lo[22:0], ~|lo[22:0],
                                                inv);
                end else if (lo[30:23] == 8'h00) begin
                    r.value_bits = trunc_to_int(lo[31], {41'd0, lo[22:0]}, -149,
                                                1'b0, 1'b0, inv);
                end else begin
                    r.value_bits = trunc_to_int(lo[31], {40'd0, 1'b1, lo[22:0]},
                                                int'(lo[30:23]) - 150, 1'b0, 1'b0, inv);
                end
            end
            ntc_pkg::TC_F64: begin
                e11 = w.raw_bytes[62:52];
                f52 = w.raw_bytes[51:0];
                neg = w.raw_bytes[63];
                if (!w.func) begin
                    if (e11 == 11'h7FF)
                        r.value_bits = (f52 == 0) ? {neg, 31'd0} | ntc_pkg::FP32_INF
                                     : {neg, 31'd0} | ntc_pkg::FP32_QNAN
                                       | {10'd0, f52[51:30]};
                    else if (e11 == 0)
                        r.value_bits = (f52 == 0) ? {neg, 31'd0}
                                     : pack_single(neg, {12'd0, f52}, -1074);
                    else
                        r.value_bits = pack_single(neg, {11'd0, 1'b1, f52}, int'(e11) - 1075);
                end else if (e11 == 11'h7FF) begin
                    r.value_bits = trunc_to_int(neg, 64'd0, 0, f52 != 0, f52 == 0, inv);
                end else if (e11 == 0) begin
                    r.value_bits = trunc_to_int(neg, {12'd0, f52}, -1074, 1'b0, 1'b0, inv);
                end else begin
                    r.value_bits = trunc_to_int(neg, {11'd0, 1'b1, f52},
                                                int'(e11) - 1075, 1'b0, 1'b0, inv);
                end
            end
            default: r = '0;
        endcase
        r.invalid = inv;
        return r;
    endfunction

    // Pushes one word and holds it until the converter accepts it.
    task automatic send_word(ntc_pkg::t_in_word w, ntc_pkg::t_out_word fixed,
                             logic use_fixed);
        while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_word <= w;
        expected_words.push_back(use_fixed ? fixed : convert_word(w));
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= (recv_stall_pct != 0) && ($urandom_range(99) < recv_stall_pct);
            if (out_valid && !out_stall) begin
                if (expected_words.size() == 0) begin
                    $error("unexpected word: value_bits %h invalid %b",
                           out_word.value_bits, out_word.invalid);
                    fail_count++;
                end else begin
                    if (out_word.value_bits !== expected_words[0].value_bits) begin
                        $error("value_bits: expected %h actual %h",
                               expected_words[0].value_bits, out_word.value_bits);
                        fail_count++;
                    end
                    if (out_word.invalid !== expected_words[0].invalid) begin
                        $error("invalid: expected %b actual %b",
                               expected_words[0].invalid, out_word.invalid);
                        fail_count++;
                    end
                    void'(expected_words.pop_front());
                end
            end
        end
    end

    function automatic ntc_pkg::t_in_word random_word();
        ntc_pkg::t_in_word w;
        logic [63:0] r;
        int          sel;
        r = {$urandom, $urandom};
        sel = $urandom_range(9);
        w.func = 1'($urandom_range(1));
        w.type_code = (sel == 0) ? 4'($urandom_range(8, 15)) : 4'($urandom_range(7));
        if (w.type_code == ntc_pkg::TC_F64 && sel < 6)
            r[62:52] = 11'($urandom_range(1023 - 160, 1023 + 40));
        else if (w.type_code == ntc_pkg::TC_F64 && sel == 6)
            r[62:52] = $urandom_range(1) ? 11'h7FF : 11'h000;
        if (w.type_code == ntc_pkg::TC_F32 && sel < 6)
            r[30:23] = 8'($urandom_range(100, 160));
        w.raw_bytes = r;
        return w;
    endfunction

    typedef struct {
        ntc_pkg::t_in_word  w;
        ntc_pkg::t_out_word res;
        logic               fixed;
    } t_row;

    t_row directed_rows[] = '{
        '{'{64'hFFFF_FFFF_FFFF_FF80, ntc_pkg::TC_I8, 1'b1}, '{32'hFFFF_FF80, 1'b0}, 1'b1},
        '{'{64'h0000_0000_0000_00FF, ntc_pkg::TC_U8, 1'b1}, '{32'h0000_00FF, 1'b0}, 1'b1},
        '{'{64'h0000_0000_0000_8000, ntc_pkg::TC_I16, 1'b0}, '{32'hC700_0000, 1'b0}, 1'b1},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, ntc_pkg::TC_U16, 1'b0}, '0, 1'b0},
        '{'{64'h0000_0000_8000_0000, ntc_pkg::TC_I32, 1'b0}, '{32'hCF00_0000, 1'b0}, 1'b1},
        '{'{64'h0000_0000_FFFF_FFFF, ntc_pkg::TC_U32, 1'b1}, '{32'hFFFF_FFFF, 1'b0}, 1'b1},
        '{'{64'h0000_0000_FFFF_FFFF, ntc_pkg::TC_U32, 1'b0}, '{32'h4F80_0000, 1'b0}, 1'b1},
        '{'{64'h0000_0000_0000_0000, ntc_pkg::TC_I32, 1'b0}, '{32'h0, 1'b0}, 1'b1},
        '{'{64'h0000_0000_7FC0_1234, ntc_pkg::TC_F32, 1'b0}, '{32'h7FC0_1234, 1'b0}, 1'b1},
        '{'{64'h0000_0000_7FC0_0001, ntc_pkg::TC_F32, 1'b1}, '{32'h0, 1'b1}, 1'b1},
        '{'{64'h0000_0000_FF80_0000, ntc_pkg::TC_F32, 1'b1}, '{ntc_pkg::I32_MIN, 1'b1}, 1'b1},
        '{'{64'h0000_0000_7F80_0000, ntc_pkg::TC_F32, 1'b1}, '{ntc_pkg::I32_MAX, 1'b1}, 1'b1},
        '{'{64'h0000_0000_CF00_0000, ntc_pkg::TC_F32, 1'b1}, '{ntc_pkg::I32_MIN, 1'b0}, 1'b1},
        '{'{64'h0000_0000_0000_0001, ntc_pkg::TC_F32, 1'b1}, '{32'h0, 1'b0}, 1'b1},
        '{'{64'h7FEF_FFFF_FFFF_FFFF, ntc_pkg::TC_F64, 1'b0}, '{ntc_pkg::FP32_INF, 1'b0}, 1'b1},
        '{'{64'hFFF8_0000_4000_0000, ntc_pkg::TC_F64, 1'b0}, '{32'hFFE0_0001, 1'b0}, 1'b1},
        '{'{64'h8000_0000_0000_0001, ntc_pkg::TC_F64, 1'b0}, '{32'h8000_0000, 1'b0}, 1'b1},
        '{'{64'h36A0_0000_0000_0001, ntc_pkg::TC_F64, 1'b0}, '0, 1'b0},
        '{'{64'h47EF_FFFF_F000_0000, ntc_pkg::TC_F64, 1'b0}, '0, 1'b0},
        '{'{64'hC1E0_0000_0000_0000, ntc_pkg::TC_F64, 1'b1}, '{ntc_pkg::I32_MIN, 1'b0}, 1'b1},
        '{'{64'hC1E0_0000_0020_0000, ntc_pkg::TC_F64, 1'b1}, '{ntc_pkg::I32_MIN, 1'b1}, 1'b1},
        '{'{64'h41DF_FFFF_FFFF_FFFF, ntc_pkg::TC_F64, 1'b1}, '0, 1'b0},
        '{'{64'h7FF0_0000_0000_0000, ntc_pkg::TC_F64, 1'b1}, '{ntc_pkg::I32_MAX, 1'b1}, 1'b1},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b1}, '{32'h0, 1'b0}, 1'b1},
        '{'{64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0}, '{32'h0, 1'b0}, 1'b1}
    };

    initial begin
        fail_count = 0;
        stim_done = 1'b0;
        send_idle_pct = 17;
        recv_stall_pct = 75;
        i_rst_n = 1'b0;
        in_valid = 1'b0;
        in_word = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (directed_rows[n])
            send_word(directed_rows[n].w, directed_rows[n].res, directed_rows[n].fixed);
        for (int n = 0; n < 500; n++) begin
            if (n == 170) begin
                send_idle_pct = 75;
                recv_stall_pct = 17;
            end else if (n == 340) begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            send_word(random_word(), '0, 1'b0);
        end
        in_valid <= 1'b0;
        recv_stall_pct = 0;
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        stim_done = 1'b1;
    end

    initial begin
        wait (stim_done);
        if (fail_count == 0)
            $display("numeric_type_converter regression: pass");
        else
            $display("numeric_type_converter regression: fail");
        $finish;
    end

    initial begin
        #2000000;
        $display("numeric_type_converter regression: fail");
        $finish;
    end
endmodule
`default_nettype wire

@@ filelist.f @@
src/ntc_pkg.sv
src/numeric_type_converter.sv
test/tb.sv
